// File: hw/rtl/jpcs_pkg.sv
// Shared types, constants and helpers for the jack pair continuity scanner.
`default_nettype none

package jpcs_pkg;

    localparam int NUM_JACKS  = 26;
    localparam int PIN_BITS   = 26;
    localparam int JACK_LIMIT = (NUM_JACKS < PIN_BITS) ? NUM_JACKS : PIN_BITS;
    localparam int JACK_W     = 5;
    localparam int CNT_W      = 4;
    localparam int SETTLE_W   = 16;
    localparam int PAIR_CAP   = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_JACKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAIRS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 2'd2;

    localparam logic [JACK_W-1:0]   ACTIVE_RESET = 5'd26;
    localparam logic [CNT_W-1:0]    MAX_RESET    = 4'd13;
    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd1000;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_DRIVE   = 2'd1;
    localparam logic [1:0] PH_RELEASE = 2'd2;

    typedef struct packed {
        logic load_in;
        logic step;
        logic emit_pair;
        logic emit_status;
    } cmd_t;

    typedef struct packed {
        logic pair_pending;
        logic out_free;
    } stat_t;

    // Index of the lowest set bit; zero when none is set.
    function automatic logic [JACK_W-1:0] lowest_set(input logic [PIN_BITS-1:0] v);
        logic [JACK_W-1:0] idx;
        idx = '0;
        for (int k = PIN_BITS - 1; k >= 0; k--)
        begin
            if (v[k])
            begin
                idx = JACK_W'(k);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/jpcs_ctrl.sv
// Controller state machine: sequences input capture, state update and result emission.
`default_nettype none

module jpcs_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire jpcs_pkg::stat_t stat,
    output jpcs_pkg::cmd_t      cmd
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_STEP = 2'd1;
    localparam logic [1:0] C_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == C_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            C_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = C_STEP;
                end
            end
            C_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = C_EMIT;
            end
            C_EMIT:
            begin
                if (stat.out_free)
                begin
                    if (stat.pair_pending)
                    begin
                        cmd.emit_pair = 1'b1;
                    end
                    else
                    begin
                        cmd.emit_status = 1'b1;
                        state_next      = C_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/jpcs_datapath.sv
// Datapath: configuration, scan state, pair candidate mask and the result register.
`default_nettype none

module jpcs_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire jpcs_pkg::cmd_t                      cmd,
    output jpcs_pkg::stat_t                          stat,
    input  wire logic                                start_scan,
    input  wire logic [jpcs_pkg::PIN_BITS-1:0]       pin_levels,
    input  wire logic                                cfg_we,
    input  wire logic [jpcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [jpcs_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     drive_enable,
    output logic [jpcs_pkg::JACK_W-1:0]              drive_jack,
    output logic                                     pair_valid,
    output logic [jpcs_pkg::JACK_W-1:0]              pair_first,
    output logic [jpcs_pkg::JACK_W-1:0]              pair_second,
    output logic [jpcs_pkg::CNT_W-1:0]               pair_total,
    output logic                                     scan_done,
    output logic                                     any_pair,
    output logic                                     busy_res,
    output logic                                     last
);

    localparam int JW = jpcs_pkg::JACK_W;
    localparam int PB = jpcs_pkg::PIN_BITS;
    localparam int CW = jpcs_pkg::CNT_W;
    localparam int SW = jpcs_pkg::SETTLE_W;

    // Configuration
    logic [JW-1:0] active_reg;
    logic [CW-1:0] max_reg;
    logic [SW-1:0] settle_cfg_reg;

    // Scan state
    logic [1:0]    phase_reg,   phase_next;
    logic [PB-1:0] present_reg, present_next;
    logic [JW-1:0] driver_reg,  driver_next;
    logic [SW-1:0] settle_reg,  settle_next;
    logic [CW-1:0] pairs_reg,   pairs_next;
    logic [PB-1:0] cand_reg,    cand_next;
    logic          done_reg,    done_next;

    // Captured input item
    logic          start_reg;
    logic [PB-1:0] pins_reg;

    logic          out_valid_reg, out_valid_next;

    // Result register
    logic          drive_enable_reg;
    logic [JW-1:0] drive_jack_reg;
    logic          pair_valid_reg;
    logic [JW-1:0] pair_first_reg;
    logic [JW-1:0] pair_second_reg;
    logic [CW-1:0] pair_total_reg;
    logic          scan_done_reg;
    logic          any_pair_reg;
    logic          busy_res_reg;
    logic          last_reg;

    // Effective configuration values
    logic [JW-1:0] eff_jacks;
    logic [CW-1:0] eff_max;
    logic [SW-1:0] eff_settle;
    logic [PB-1:0] jack_mask;

    logic [PB-1:0] present_src;
    logic [CW-1:0] pairs_src;
    logic [JW:0]   search_from;
    logic [PB-1:0] elig;
    logic          drv_found;
    logic [JW-1:0] drv_idx;
    logic [PB-1:0] cand_comb;
    logic [PB-1:0] cand_clear;

    always_comb
    begin
        eff_jacks = (active_reg > JW'(jpcs_pkg::JACK_LIMIT)) ?
                    JW'(jpcs_pkg::JACK_LIMIT) : active_reg;
        eff_max   = (max_reg > CW'(jpcs_pkg::PAIR_CAP)) ? CW'(jpcs_pkg::PAIR_CAP) : max_reg;
        eff_settle = (settle_cfg_reg == '0) ? SW'(1) : settle_cfg_reg;
        for (int k = 0; k < PB; k++)
        begin
            jack_mask[k] = ((JW+1)'(k) < {1'b0, eff_jacks});
        end
    end

    // A start tick searches the freshly latched mask from jack zero with no pairs yet.
    always_comb
    begin
        present_src = (phase_reg == jpcs_pkg::PH_IDLE) ? (pins_reg & jack_mask) : present_reg;
        pairs_src   = (phase_reg == jpcs_pkg::PH_IDLE) ? '0 : pairs_reg;
        search_from = (phase_reg == jpcs_pkg::PH_IDLE) ? '0 : ({1'b0, driver_reg} + (JW+1)'(1));
        for (int k = 0; k < PB; k++)
        begin
            elig[k] = present_src[k] && ((JW+1)'(k) >= search_from) &&
                      ((JW+1)'(k + 1) < {1'b0, eff_jacks});
            cand_comb[k] = present_reg[k] && !pins_reg[k] &&
                           ((JW+1)'(k) > {1'b0, driver_reg}) &&
                           ((JW+1)'(k) < {1'b0, eff_jacks});
        end
        drv_found  = (elig != '0) && (pairs_src < eff_max);
        drv_idx    = jpcs_pkg::lowest_set(elig);
        cand_clear = cand_reg & (cand_reg - PB'(1));
    end

    always_comb
    begin
        phase_next   = phase_reg;
        present_next = present_reg;
        driver_next  = driver_reg;
        settle_next  = settle_reg;
        pairs_next   = pairs_reg;
        cand_next    = cand_reg;
        done_next    = done_reg;
        if (cmd.step)
        begin
            done_next = 1'b0;
            cand_next = '0;
            priority if (phase_reg == jpcs_pkg::PH_IDLE)
            begin
                if (start_reg)
                begin
                    present_next = pins_reg & jack_mask;
                    pairs_next   = '0;
                    if (drv_found)
                    begin
                        phase_next  = jpcs_pkg::PH_DRIVE;
                        driver_next = drv_idx;
                        settle_next = eff_settle;
                    end
                    else
                    begin
                        driver_next = '0;
                        settle_next = '0;
                        done_next   = 1'b1;
                    end
                end
            end
            else if (settle_reg > SW'(1))
            begin
                settle_next = settle_reg - SW'(1);
            end
            else if (phase_reg == jpcs_pkg::PH_DRIVE)
            begin
                cand_next   = cand_comb;
                phase_next  = jpcs_pkg::PH_RELEASE;
                settle_next = eff_settle;
            end
            else
            begin
                if (drv_found)
                begin
                    phase_next  = jpcs_pkg::PH_DRIVE;
                    driver_next = drv_idx;
                    settle_next = eff_settle;
                end
                else
                begin
                    phase_next  = jpcs_pkg::PH_IDLE;
                    driver_next = '0;
                    settle_next = '0;
                    done_next   = 1'b1;
                end
            end
        end
        else if (cmd.emit_pair)
        begin
            cand_next  = cand_clear;
            pairs_next = pairs_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= jpcs_pkg::ACTIVE_RESET;
            max_reg        <= jpcs_pkg::MAX_RESET;
            settle_cfg_reg <= jpcs_pkg::SETTLE_RESET;
            phase_reg      <= jpcs_pkg::PH_IDLE;
            present_reg    <= '0;
            driver_reg     <= '0;
            settle_reg     <= '0;
            pairs_reg      <= '0;
            cand_reg       <= '0;
            done_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    jpcs_pkg::CFG_ACTIVE_JACKS: active_reg     <= cfg_data[JW-1:0];
                    jpcs_pkg::CFG_MAX_PAIRS:    max_reg        <= cfg_data[CW-1:0];
                    jpcs_pkg::CFG_SETTLE_TICKS: settle_cfg_reg <= cfg_data[SW-1:0];
                    default:                    ;
                endcase
            end
            phase_reg     <= phase_next;
            present_reg   <= present_next;
            driver_reg    <= driver_next;
            settle_reg    <= settle_next;
            pairs_reg     <= pairs_next;
            cand_reg      <= cand_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit_pair || cmd.emit_status)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            start_reg <= start_scan;
            pins_reg  <= pin_levels;
        end
        if (cmd.emit_pair || cmd.emit_status)
        begin
            drive_enable_reg <= (phase_reg == jpcs_pkg::PH_DRIVE);
            drive_jack_reg   <= (phase_reg == jpcs_pkg::PH_DRIVE) ? driver_reg : '0;
            busy_res_reg     <= (phase_reg != jpcs_pkg::PH_IDLE);
            pair_valid_reg   <= cmd.emit_pair;
            pair_first_reg   <= cmd.emit_pair ? driver_reg : '0;
            pair_second_reg  <= cmd.emit_pair ? jpcs_pkg::lowest_set(cand_reg) : '0;
            pair_total_reg   <= cmd.emit_pair ? (pairs_reg + CW'(1)) : pairs_reg;
            scan_done_reg    <= cmd.emit_status && done_reg;
            any_pair_reg     <= cmd.emit_status && done_reg && (pairs_reg != '0);
            last_reg         <= cmd.emit_status;
        end
    end

    assign out_valid         = out_valid_reg;
    assign drive_enable      = drive_enable_reg;
    assign drive_jack        = drive_jack_reg;
    assign pair_valid        = pair_valid_reg;
    assign pair_first        = pair_first_reg;
    assign pair_second       = pair_second_reg;
    assign pair_total        = pair_total_reg;
    assign scan_done         = scan_done_reg;
    assign any_pair          = any_pair_reg;
    assign busy_res          = busy_res_reg;
    assign last              = last_reg;
    assign stat.out_free     = !out_valid_reg || out_ready;
    assign stat.pair_pending = (cand_reg != '0) && (pairs_reg < eff_max);

endmodule

`default_nettype wire

// File: hw/rtl/jack_pair_continuity_scanner_top.sv
// Top level of the jack pair continuity scanner: controller plus datapath.
//
//   Channel   Handshake               Payload
//   input     in_valid / in_ready     start_scan, pin_levels
//   result    out_valid / out_ready   drive_enable .. last (ten fields)
//   config    cfg_we                  cfg_index, cfg_data
//
// Each input item is accepted, then the scan state is updated, then its results
// leave the single output register in turn: P pair results, where P is the
// number of pairs it reports (0 to 13), followed by one status result.
// A stalled output holds the emitter; no new item is accepted until the status
// result of the current one is loaded. Reset clears all control and scan state.
`default_nettype none

module jack_pair_continuity_scanner_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                start_scan,
    input  wire logic [jpcs_pkg::PIN_BITS-1:0]       pin_levels,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     drive_enable,
    output logic [jpcs_pkg::JACK_W-1:0]              drive_jack,
    output logic                                     pair_valid,
    output logic [jpcs_pkg::JACK_W-1:0]              pair_first,
    output logic [jpcs_pkg::JACK_W-1:0]              pair_second,
    output logic [jpcs_pkg::CNT_W-1:0]               pair_total,
    output logic                                     scan_done,
    output logic                                     any_pair,
    output logic                                     busy_res,
    output logic                                     last,
    input  wire logic                                cfg_we,
    input  wire logic [jpcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [jpcs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    jpcs_pkg::cmd_t  cmd;
    jpcs_pkg::stat_t stat;

    jpcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    jpcs_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .start_scan   (start_scan),
        .pin_levels   (pin_levels),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .drive_enable (drive_enable),
        .drive_jack   (drive_jack),
        .pair_valid   (pair_valid),
        .pair_first   (pair_first),
        .pair_second  (pair_second),
        .pair_total   (pair_total),
        .scan_done    (scan_done),
        .any_pair     (any_pair),
        .busy_res     (busy_res),
        .last         (last)
    );

endmodule

`default_nettype wire

// File: hw/rtl/jpcs_checker.sv
// Port-level checker for the scanner top level, with its bind statement.
`default_nettype none

module jpcs_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_ready,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic                                drive_enable,
    input wire logic [jpcs_pkg::JACK_W-1:0]         drive_jack,
    input wire logic                                pair_valid,
    input wire logic [jpcs_pkg::JACK_W-1:0]         pair_first,
    input wire logic [jpcs_pkg::JACK_W-1:0]         pair_second,
    input wire logic [jpcs_pkg::CNT_W-1:0]          pair_total,
    input wire logic                                scan_done,
    input wire logic                                any_pair,
    input wire logic                                busy_res,
    input wire logic                                last
);

    // A result that is not taken must be held unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pair_first) &&
        $stable(pair_second) && $stable(pair_total) && $stable(last))
        else $error("result changed while stalled");

    // A pair item joins a later jack to a lower driver and is never the final item.
    a_pair_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pair_valid |-> !last && !scan_done && (pair_first < pair_second) &&
        (pair_total != '0) && busy_res && !drive_enable)
        else $error("malformed pair item");

    // The end of a scan leaves the block idle with nothing driven.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scan_done |-> last && !busy_res && !drive_enable && (drive_jack == '0))
        else $error("scan end with block still busy");

    a_any_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && any_pair |-> scan_done && (pair_total != '0))
        else $error("any_pair without a finished scan that found pairs");

    // No new item is taken while its previous results are still being sent.
    a_no_accept_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pair_valid |-> !in_ready)
        else $error("input accepted before status item of previous item");

endmodule

bind jack_pair_continuity_scanner_top jpcs_checker u_jpcs_checker (.*);

`default_nettype wire
